// ===== rtl/core/msub_pkg.sv =====
package msub_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_GRID  = 16;
  localparam int IDX_W     = 12;
  localparam int SUM_W     = 16;
  localparam int CNT_W     = 9;
  localparam int CNT_TAB   = 256;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GRID_SIZE    = 3'd2;
  localparam logic [2:0] REG_INVERT_MASK  = 3'd3;
  localparam logic [2:0] REG_MIN_PIXELS   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
  } acc_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic first;
    logic unmasked;
  } acc_ctl_t;

endpackage

// ===== rtl/core/msub_acc.sv =====
module msub_acc (
  input  logic                          clk,
  input  msub_pkg::acc_ctl_t            ctl,
  input  logic [msub_pkg::IDX_W-1:0]    idx,
  input  logic [7:0]                    pix_red,
  input  logic [7:0]                    pix_green,
  input  logic [7:0]                    pix_blue,
  output msub_pkg::acc_entry_t          entry_q
);

  msub_pkg::acc_entry_t mem [msub_pkg::MAX_WIDTH];
  msub_pkg::acc_entry_t rd_q_r;
  msub_pkg::acc_entry_t base;
  msub_pkg::acc_entry_t upd_nxt;
  msub_pkg::acc_entry_t upd_r;

  // The first pixel of a cell starts from an empty entry instead of the stored one.
  always_comb begin
    base = ctl.first ? '0 : rd_q_r;
    upd_nxt = base;
    if (ctl.unmasked) begin
      upd_nxt.red   = base.red   + msub_pkg::SUM_W'(pix_red);
      upd_nxt.green = base.green + msub_pkg::SUM_W'(pix_green);
      upd_nxt.blue  = base.blue  + msub_pkg::SUM_W'(pix_blue);
      upd_nxt.count = base.count + msub_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_r <= mem[idx];
    end
    if (ctl.wr_en) begin
      mem[idx] <= upd_nxt;
      upd_r    <= upd_nxt;
    end
  end

  assign entry_q = upd_r;

endmodule

// ===== rtl/core/msub_div.sv =====
module msub_div (
  input  logic                              clk,
  input  logic                              load,
  input  msub_pkg::acc_entry_t              entry,
  input  logic [msub_pkg::CNT_W-1:0]        min_pixels,
  output logic [7:0]                        avg_red,
  output logic [7:0]                        avg_green,
  output logic [7:0]                        avg_blue,
  output logic                              cell_masked
);

  localparam int RECIP_W = 25;
  localparam int PROD_W  = msub_pkg::SUM_W + RECIP_W;

  logic [RECIP_W-1:0] recip_tab [msub_pkg::CNT_TAB];

  // recip_tab[c-1] is ceil(2^24 / c), exact for any 16-bit sum and count up to 256.
  for (genvar i = 0; i < msub_pkg::CNT_TAB; i++) begin : g_recip
    localparam logic [RECIP_W-1:0] M = RECIP_W'(((1 << 24) + i) / (i + 1));
    assign recip_tab[i] = M;
  end

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_red_r;
  logic [PROD_W-1:0]  prod_green_r;
  logic [PROD_W-1:0]  prod_blue_r;
  logic               masked_r;
  logic [PROD_W-25:0] q_red;
  logic [PROD_W-25:0] q_green;
  logic [PROD_W-25:0] q_blue;

  assign recip = recip_tab[8'(entry.count - msub_pkg::CNT_W'(1))];

  always_ff @(posedge clk) begin
    if (load) begin
      prod_red_r   <= PROD_W'(entry.red)   * PROD_W'(recip);
      prod_green_r <= PROD_W'(entry.green) * PROD_W'(recip);
      prod_blue_r  <= PROD_W'(entry.blue)  * PROD_W'(recip);
      masked_r     <= (entry.count == '0) || (entry.count < min_pixels);
    end
  end

  assign q_red   = prod_red_r[PROD_W-1:24];
  assign q_green = prod_green_r[PROD_W-1:24];
  assign q_blue  = prod_blue_r[PROD_W-1:24];

  always_comb begin
    if (masked_r) begin
      avg_red   = 8'hFF;
      avg_green = 8'h00;
      avg_blue  = 8'h00;
    end else begin
      avg_red   = (q_red   > 255) ? 8'hFF : q_red[7:0];
      avg_green = (q_green > 255) ? 8'hFF : q_green[7:0];
      avg_blue  = (q_blue  > 255) ? 8'hFF : q_blue[7:0];
    end
  end

  assign cell_masked = masked_r;

endmodule

// ===== rtl/core/masked_block_average_subsample_unit.sv =====
// Masked box-downsample averager.
// Input stream: one RGB pixel per transaction in raster order; in_tdata holds
// red, green, blue from bit 0 up and in_tuser[0] is the mask bit.
// Output stream: one transaction per closed grid cell with the per-channel
// average (or pure red for a masked cell); out_tlast marks the last cell of a
// cell row, out_tuser[0] the masked flag and out_tuser[1] the end of frame.
// Each pixel goes through the following steps, and the next pixel is taken only
// after them: forming the cell column address with the reciprocal multiplier,
// the synchronous read of the accumulator memory and the update write. A pixel
// that closes a cell then passes the reciprocal division and is registered.
// The result sits in an output register, so new pixels are taken while it
// waits; only the next closing pixel waits for it to be taken.
// Reset returns all positions to the start of a frame and the registers to
// their defaults; the accumulator memory is not cleared, since the first pixel
// of every cell overwrites its entry. Registers are to be written through the
// APB-style port only while the stream is idle; the block does not enforce this.
module masked_block_average_subsample_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic [0:0]  in_tuser,   // mask_bit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // avg_red, avg_green, avg_blue
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // cell_masked, end_of_frame
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int GR_W = 17;
  localparam int GP_W = msub_pkg::IDX_W + GR_W;

  logic [12:0] image_width_r;
  logic [14:0] image_height_r;
  logic [4:0]  grid_size_r;
  logic        invert_mask_r;
  logic [8:0]  min_pixels_r;
  logic        cfg_wr;

  msub_pkg::state_t state_r, state_nxt;

  logic [11:0] col_pos_r;
  logic [14:0] row_pos_r;
  logic [3:0]  cic_r;
  logic [3:0]  ric_r;

  logic [11:0] wm1;
  logic [14:0] hm1;
  logic [3:0]  gm1;
  logic        row_end, frame_row_end, cell_col_end, cell_row_end;
  logic        in_fire;
  logic        out_load;

  logic [7:0]       pix_red_r, pix_green_r, pix_blue_r;
  logic             unmasked_r, first_r, close_r, eor_r, eof_r;
  logic [GP_W-1:0]  gprod_r;
  logic             div_load;

  logic [GR_W-1:0]  grid_recip [msub_pkg::MAX_GRID];

  msub_pkg::acc_ctl_t   acc_ctl;
  msub_pkg::acc_entry_t acc_entry;

  logic [7:0] d_red, d_green, d_blue;
  logic       d_masked;

  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;
  logic        out_tlast_r;
  logic [1:0]  out_tuser_r;
  logic        eor_hold_r, eof_hold_r;

  // grid_recip[g-1] is ceil(2^16 / g), exact for 12-bit column positions.
  for (genvar i = 0; i < msub_pkg::MAX_GRID; i++) begin : g_grid
    localparam logic [GR_W-1:0] M = GR_W'(((1 << 16) + i) / (i + 1));
    assign grid_recip[i] = M;
  end

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 13'd4096;
      image_height_r <= 15'd32767;
      grid_size_r    <= 5'd1;
      invert_mask_r  <= 1'b0;
      min_pixels_r   <= 9'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        msub_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[12:0];
        msub_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[14:0];
        msub_pkg::REG_GRID_SIZE:    grid_size_r    <= cfg_pwdata[4:0];
        msub_pkg::REG_INVERT_MASK:  invert_mask_r  <= cfg_pwdata[0];
        msub_pkg::REG_MIN_PIXELS:   min_pixels_r   <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      msub_pkg::REG_IMAGE_WIDTH:  cfg_prdata = {19'd0, image_width_r};
      msub_pkg::REG_IMAGE_HEIGHT: cfg_prdata = {17'd0, image_height_r};
      msub_pkg::REG_GRID_SIZE:    cfg_prdata = {27'd0, grid_size_r};
      msub_pkg::REG_INVERT_MASK:  cfg_prdata = {31'd0, invert_mask_r};
      msub_pkg::REG_MIN_PIXELS:   cfg_prdata = {23'd0, min_pixels_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // Effective limits, less one, with out-of-range settings clamped.
  always_comb begin
    if (image_width_r == '0) begin
      wm1 = '0;
    end else if (image_width_r > 13'(msub_pkg::MAX_WIDTH)) begin
      wm1 = 12'(msub_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = 12'(image_width_r - 13'd1);
    end
    hm1 = (image_height_r == '0) ? '0 : image_height_r - 15'd1;
    if (grid_size_r == '0) begin
      gm1 = '0;
    end else if (grid_size_r > 5'(msub_pkg::MAX_GRID)) begin
      gm1 = 4'(msub_pkg::MAX_GRID - 1);
    end else begin
      gm1 = 4'(grid_size_r - 5'd1);
    end
  end

  assign row_end       = col_pos_r >= wm1;
  assign frame_row_end = row_pos_r >= hm1;
  assign cell_col_end  = row_end || (cic_r >= gm1);
  assign cell_row_end  = frame_row_end || (ric_r >= gm1);
  assign in_fire       = in_tvalid && in_tready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msub_pkg::ST_IDLE:   if (in_fire) state_nxt = msub_pkg::ST_READ;
      msub_pkg::ST_READ:   state_nxt = msub_pkg::ST_UPDATE;
      msub_pkg::ST_UPDATE: state_nxt = close_r ? msub_pkg::ST_DIV : msub_pkg::ST_IDLE;
      msub_pkg::ST_DIV:    state_nxt = msub_pkg::ST_OUT;
      msub_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = msub_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msub_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = (state_r == msub_pkg::ST_IDLE);
    acc_ctl.rd_en    = (state_r == msub_pkg::ST_READ);
    acc_ctl.wr_en    = (state_r == msub_pkg::ST_UPDATE);
    acc_ctl.first    = first_r;
    acc_ctl.unmasked = unmasked_r;
    div_load         = (state_r == msub_pkg::ST_DIV);
    out_load         = (state_r == msub_pkg::ST_OUT) && (!out_tvalid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= msub_pkg::ST_IDLE;
      col_pos_r <= '0;
      row_pos_r <= '0;
      cic_r     <= '0;
      ric_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        if (row_end) begin
          col_pos_r <= '0;
          cic_r     <= '0;
          if (frame_row_end) begin
            row_pos_r <= '0;
            ric_r     <= '0;
          end else begin
            row_pos_r <= row_pos_r + 15'd1;
            ric_r     <= (ric_r >= gm1) ? '0 : ric_r + 4'd1;
          end
        end else begin
          col_pos_r <= col_pos_r + 12'd1;
          cic_r     <= (cic_r >= gm1) ? '0 : cic_r + 4'd1;
        end
      end
    end
  end

  // Transaction capture: pixel, flags and the cell column product.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_red_r   <= in_tdata[7:0];
      pix_green_r <= in_tdata[15:8];
      pix_blue_r  <= in_tdata[23:16];
      unmasked_r  <= !(in_tuser[0] ^ invert_mask_r);
      first_r     <= (ric_r == '0) && (cic_r == '0);
      close_r     <= cell_col_end && cell_row_end;
      eor_r       <= row_end;
      eof_r       <= row_end && frame_row_end;
      gprod_r     <= GP_W'(col_pos_r) * GP_W'(grid_recip[gm1]);
    end
    if (div_load) begin
      eor_hold_r <= eor_r;
      eof_hold_r <= eof_r;
    end
  end

  msub_acc u_acc (
    .clk       (clk),
    .ctl       (acc_ctl),
    .idx       (gprod_r[16 +: msub_pkg::IDX_W]),
    .pix_red   (pix_red_r),
    .pix_green (pix_green_r),
    .pix_blue  (pix_blue_r),
    .entry_q   (acc_entry)
  );

  msub_div u_div (
    .clk         (clk),
    .load        (div_load),
    .entry       (acc_entry),
    .min_pixels  (min_pixels_r),
    .avg_red     (d_red),
    .avg_green   (d_green),
    .avg_blue    (d_blue),
    .cell_masked (d_masked)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {d_blue, d_green, d_red};
      out_tlast_r <= eor_hold_r;
      out_tuser_r <= {eof_hold_r, d_masked};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  a_fire_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == msub_pkg::ST_READ)
    else $error("accepted pixel did not start a memory read");

  a_div_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == msub_pkg::ST_DIV |-> $past(state_r == msub_pkg::ST_UPDATE) && $past(close_r))
    else $error("division started without a closing update");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == msub_pkg::ST_OUT))
    else $error("result appeared outside the output step");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msub_pkg::ST_OUT && out_tvalid_r && !out_tready) |=>
    state_r == msub_pkg::ST_OUT)
    else $error("result dropped while the output register was full");

endmodule
